// ===== hw/rtl/ale_pkg.sv =====
package ale_pkg;

    localparam int LIST_DEPTH = 128;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int POS_W      = 8;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_LOCATE = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    typedef logic [WORD_WIDTH-1:0] t_word;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_READ,
        CMD_LOCATE,
        CMD_INSERT,
        CMD_DELETE,
        CMD_CLEAR,
        CMD_BAD
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_SCAN,
        S_SHIFT_UP,
        S_PLACE,
        S_SHIFT_DN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]        operation;
        logic [POS_W-1:0]  position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [6:0]         found_position;
        logic [7:0]         list_count;
        logic               is_empty;
    } t_out_item;

    typedef struct packed {
        t_cmd             cmd;
        logic [POS_W-1:0] position;
        t_word            value;
    } t_cmd_word;

endpackage

// ===== hw/rtl/array_list_engine_unit.sv =====
// Bounded ordered list of signed words, one operation per input word.
// Input queue: drive i_item and raise push while full is low; the word is
// taken at that edge. Up to two words wait ahead of the list sequencer.
// Result queue: while empty is low, o_result holds the oldest result; raise
// pop to take it. One result comes back for every input word, in order.
// Sequencer occupancy per word depends on the operation, the position and
// the length, set by the one-read one-write cell memory: insert shifts the
// tail up one cell at a time and delete shifts it down, except when
// appending or deleting the last word; locate scans from the head.
// The next word starts once the previous one has left the sequencer.
// A stalled result holds the sequencer in its final step; later words
// collect in the input queue until full rises. Nothing is dropped.
// Reset empties both queues and sets the length to zero; cell contents
// are left as they are and are only read below the length.
module array_list_engine_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  ale_pkg::t_in_item   i_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output ale_pkg::t_out_item  o_result
);

    logic               cmd_valid;
    ale_pkg::t_cmd_word cmd;
    logic               cmd_take;
    logic               res_valid;

    ale_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    ale_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_res_valid (res_valid),
        .o_res       (o_result),
        .i_res_take  (pop)
    );

    assign empty = !res_valid;

endmodule

// ===== hw/rtl/ale_ram.sv =====
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ale_front.sv =====
module ale_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ale_pkg::t_in_item   i_item,
    output logic                o_full,
    output logic                o_cmd_valid,
    output ale_pkg::t_cmd_word  o_cmd,
    input  logic                i_cmd_take
);

    function automatic ale_pkg::t_cmd classify(input logic [2:0] op);
        ale_pkg::t_cmd c;
        case (op)
            ale_pkg::OP_READ:   c = ale_pkg::CMD_READ;
            ale_pkg::OP_LOCATE: c = ale_pkg::CMD_LOCATE;
            ale_pkg::OP_INSERT: c = ale_pkg::CMD_INSERT;
            ale_pkg::OP_DELETE: c = ale_pkg::CMD_DELETE;
            ale_pkg::OP_CLEAR:  c = ale_pkg::CMD_CLEAR;
            default:            c = ale_pkg::CMD_BAD;
        endcase
        return c;
    endfunction

    ale_pkg::t_cmd_word              r_slot [ale_pkg::CMDQ_DEPTH];
    logic [ale_pkg::CMDQ_AW-1:0]     r_wr_ptr;
    logic [ale_pkg::CMDQ_AW-1:0]     r_rd_ptr;
    logic [ale_pkg::CMDQ_CW-1:0]     r_cnt;
    logic [ale_pkg::CMDQ_AW-1:0]     n_wr_ptr;
    logic [ale_pkg::CMDQ_AW-1:0]     n_rd_ptr;
    logic [ale_pkg::CMDQ_CW-1:0]     n_cnt;
    logic                            push_ok;
    logic                            pop_ok;
    ale_pkg::t_cmd_word              new_cmd;

    assign o_full      = (r_cnt == ale_pkg::CMDQ_CW'(ale_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_cmd_take && o_cmd_valid;

    always_comb begin
        new_cmd.cmd      = classify(i_item.operation);
        new_cmd.position = i_item.position;
        new_cmd.value    = ale_pkg::t_word'($unsigned(i_item.value));
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == ale_pkg::CMDQ_AW'(ale_pkg::CMDQ_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == ale_pkg::CMDQ_AW'(ale_pkg::CMDQ_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= new_cmd;
        end
    end

endmodule

// ===== hw/rtl/ale_back.sv =====
module ale_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  ale_pkg::t_cmd_word  i_cmd,
    output logic                o_cmd_take,
    output logic                o_res_valid,
    output ale_pkg::t_out_item  o_res,
    input  logic                i_res_take
);

    ale_pkg::t_state    r_state;
    ale_pkg::t_state    n_state;
    ale_pkg::t_cnt      r_len;
    ale_pkg::t_cnt      n_len;
    ale_pkg::t_addr     r_k;
    ale_pkg::t_addr     n_k;
    ale_pkg::t_addr     r_pos;
    ale_pkg::t_addr     n_pos;
    ale_pkg::t_word     r_val;
    ale_pkg::t_word     n_val;
    ale_pkg::t_status   r_status;
    ale_pkg::t_status   n_status;
    ale_pkg::t_word     r_rd;
    ale_pkg::t_word     n_rd;
    ale_pkg::t_addr     r_found;
    ale_pkg::t_addr     n_found;
    logic               r_res_valid;
    ale_pkg::t_out_item r_res;

    logic               ram_we;
    ale_pkg::t_addr     ram_waddr;
    ale_pkg::t_word     ram_wdata;
    logic               ram_re;
    ale_pkg::t_addr     ram_raddr;
    ale_pkg::t_word     ram_rdata;

    logic [ale_pkg::CMP_W-1:0] head_pos_w;
    logic [ale_pkg::CMP_W-1:0] len_w;
    ale_pkg::t_addr            head_addr;
    logic                      h_lt;
    logic                      h_gt;
    logic                      h_eq;
    logic                      h_last;
    logic                      len_full;
    logic                      len_zero;
    logic                      k_last;
    logic                      up_last;
    logic                      hit;
    logic                      res_free;
    logic                      res_load;

    assign head_pos_w = ale_pkg::CMP_W'(i_cmd.position);
    assign len_w      = ale_pkg::CMP_W'(r_len);
    assign head_addr  = ale_pkg::t_addr'(i_cmd.position);
    assign h_lt       = head_pos_w < len_w;
    assign h_gt       = head_pos_w > len_w;
    assign h_eq       = head_pos_w == len_w;
    assign h_last     = (head_pos_w + 1'b1) == len_w;
    assign len_full   = r_len >= ale_pkg::CNT_W'(ale_pkg::LIST_DEPTH);
    assign len_zero   = r_len == '0;
    assign k_last     = (ale_pkg::CNT_W'(r_k) + 1'b1) == r_len;
    assign up_last    = r_k == r_pos;
    assign hit        = ram_rdata == r_val;
    assign res_free   = !r_res_valid || i_res_take;

    ale_ram #(
        .WIDTH (ale_pkg::WORD_WIDTH),
        .DEPTH (ale_pkg::LIST_DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ale_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.cmd)
                        ale_pkg::CMD_READ: begin
                            n_state = h_lt ? ale_pkg::S_RDWAIT : ale_pkg::S_DONE;
                        end
                        ale_pkg::CMD_LOCATE: begin
                            n_state = len_zero ? ale_pkg::S_DONE : ale_pkg::S_SCAN;
                        end
                        ale_pkg::CMD_INSERT: begin
                            n_state = (h_lt && !len_full) ? ale_pkg::S_SHIFT_UP :
                                      ale_pkg::S_DONE;
                        end
                        ale_pkg::CMD_DELETE: begin
                            n_state = (h_lt && !h_last) ? ale_pkg::S_SHIFT_DN :
                                      ale_pkg::S_DONE;
                        end
                        default: begin
                            n_state = ale_pkg::S_DONE;
                        end
                    endcase
                end
            end
            ale_pkg::S_RDWAIT: begin
                n_state = ale_pkg::S_DONE;
            end
            ale_pkg::S_SCAN: begin
                if (hit || k_last) begin
                    n_state = ale_pkg::S_DONE;
                end
            end
            ale_pkg::S_SHIFT_UP: begin
                if (up_last) begin
                    n_state = ale_pkg::S_PLACE;
                end
            end
            ale_pkg::S_PLACE: begin
                n_state = ale_pkg::S_DONE;
            end
            ale_pkg::S_SHIFT_DN: begin
                if (k_last) begin
                    n_state = ale_pkg::S_DONE;
                end
            end
            ale_pkg::S_DONE: begin
                if (res_free) begin
                    n_state = ale_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ale_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_len      = r_len;
        n_k        = r_k;
        n_pos      = r_pos;
        n_val      = r_val;
        n_status   = r_status;
        n_rd       = r_rd;
        n_found    = r_found;
        o_cmd_take = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_k;
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;
        ram_raddr  = r_k;
        res_load   = 1'b0;
        case (r_state)
            ale_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    n_pos      = head_addr;
                    n_val      = i_cmd.value;
                    n_status   = ale_pkg::ST_OK;
                    n_rd       = '0;
                    n_found    = '0;
                    case (i_cmd.cmd)
                        ale_pkg::CMD_READ: begin
                            if (h_lt) begin
                                ram_re    = 1'b1;
                                ram_raddr = head_addr;
                            end else begin
                                n_status = ale_pkg::ST_BADPOS;
                            end
                        end
                        ale_pkg::CMD_LOCATE: begin
                            if (len_zero) begin
                                n_status = ale_pkg::ST_NOTFOUND;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_k       = '0;
                            end
                        end
                        ale_pkg::CMD_INSERT: begin
                            if (h_gt) begin
                                n_status = ale_pkg::ST_BADPOS;
                            end else if (len_full) begin
                                n_status = ale_pkg::ST_FULL;
                            end else if (h_eq) begin
                                ram_we    = 1'b1;
                                ram_waddr = head_addr;
                                ram_wdata = i_cmd.value;
                                n_len     = r_len + 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = ale_pkg::t_addr'(r_len - 1'b1);
                                n_k       = ale_pkg::t_addr'(r_len - 1'b1);
                            end
                        end
                        ale_pkg::CMD_DELETE: begin
                            if (!h_lt) begin
                                n_status = ale_pkg::ST_BADPOS;
                            end else if (h_last) begin
                                n_len = r_len - 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = head_addr + 1'b1;
                                n_k       = head_addr + 1'b1;
                            end
                        end
                        ale_pkg::CMD_CLEAR: begin
                            n_len = '0;
                        end
                        default: begin
                            n_status = ale_pkg::ST_BADPOS;
                        end
                    endcase
                end
            end
            ale_pkg::S_RDWAIT: begin
                n_rd = ram_rdata;
            end
            ale_pkg::S_SCAN: begin
                if (hit) begin
                    n_found = r_k;
                end else if (k_last) begin
                    n_status = ale_pkg::ST_NOTFOUND;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_k + 1'b1;
                    n_k       = r_k + 1'b1;
                end
            end
            ale_pkg::S_SHIFT_UP: begin
                ram_we    = 1'b1;
                ram_waddr = r_k + 1'b1;
                ram_wdata = ram_rdata;
                if (!up_last) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_k - 1'b1;
                    n_k       = r_k - 1'b1;
                end
            end
            ale_pkg::S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = r_val;
                n_len     = r_len + 1'b1;
            end
            ale_pkg::S_SHIFT_DN: begin
                ram_we    = 1'b1;
                ram_waddr = r_k - 1'b1;
                ram_wdata = ram_rdata;
                if (k_last) begin
                    n_len = r_len - 1'b1;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_k + 1'b1;
                    n_k       = r_k + 1'b1;
                end
            end
            ale_pkg::S_DONE: begin
                res_load = res_free;
            end
            default: begin
                res_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ale_pkg::S_IDLE;
            r_len       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_take) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_found  <= n_found;
        if (res_load) begin
            r_res.status         <= r_status;
            r_res.read_value     <= 32'(r_rd);
            r_res.found_position <= 7'(r_found);
            r_res.list_count     <= 8'(r_len);
            r_res.is_empty       <= (r_len == '0);
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== hw/rtl/ale_checker.sv =====
module ale_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input ale_pkg::t_out_item o_result
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_reset_open: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input queue full after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("stalled result changed");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.is_empty == (o_result.list_count == 8'd0)))
        else $error("empty flag disagrees with count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.list_count <= 8'(ale_pkg::LIST_DEPTH)))
        else $error("count beyond list depth");

endmodule

bind array_list_engine_unit ale_checker u_ale_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
